// ===== design/amsb_pkg.sv =====
// shared types, codes and packing constants for the axis move sequencer
`default_nettype none
package amsb_pkg;

	// input item kinds carried in tuser
	typedef enum logic [2:0] {
		MODE_REL  = 3'd0,
		MODE_ABS  = 3'd1,
		MODE_POLL = 3'd2,
		MODE_DONE = 3'd3,
		MODE_STOP = 3'd4
	} mode_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE         = 3'd0,
		ST_WAIT_BACKLASH = 3'd1,
		ST_START        = 3'd2,
		ST_WAIT_MOVE    = 3'd3,
		ST_DONE         = 3'd4
	} state_t;

	// last travel direction
	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_POS  = 2'd1,
		DIR_NEG  = 2'd2
	} dir_t;

	// profile select codes
	typedef enum logic [1:0] {
		PROF_NONE = 2'd0,
		PROF_MOVE = 2'd1,
		PROF_TURN = 2'd2
	} prof_t;

	// move kinds
	typedef enum logic [1:0] {
		KIND_SYNC   = 2'd0,
		KIND_JOG    = 2'd1,
		KIND_MAXSPD = 2'd2,
		KIND_TURN   = 2'd3
	} kind_t;

	localparam int unsigned LOC_W   = 32;
	localparam int unsigned DIST_W  = 31;
	localparam int unsigned BL_W    = 16;
	localparam int unsigned IN_TDATA_W  = 72;
	localparam int unsigned OUT_TDATA_W = 48;

	// one input item
	typedef struct packed {
		logic [2:0]       mode;
		logic [LOC_W-1:0] target;
		logic [1:0]       command_type;
		logic [LOC_W-1:0] current_location;
	} item_t;

	// signed distance split into direction and saturated magnitude
	typedef struct packed {
		logic              zero;
		logic              neg;
		logic [DIST_W-1:0] mag;
	} dist_t;

	// one result item
	typedef struct packed {
		logic              ctl_write;
		logic              ctl_start;
		logic              ctl_backlash;
		logic              ctl_dir_pos;
		logic              ctl_sync;
		logic [1:0]        profile_load;
		logic              distance_write;
		logic [DIST_W-1:0] distance_value;
		logic [2:0]        axis_state;
		logic              busy_res;
		logic              position_error;
	} res_t;

endpackage
`default_nettype wire

// ===== design/amsb_dist.sv =====
// move distance: relative or absolute, split into direction and saturated magnitude
`default_nettype none
module amsb_dist (
	input  wire amsb_pkg::item_t item,
	output amsb_pkg::dist_t      span
);
	import amsb_pkg::*;

	logic [LOC_W:0] tgt_x;
	logic [LOC_W:0] loc_x;
	logic [LOC_W:0] diff;
	logic [LOC_W:0] mag_x;

	// exact 33-bit signed distance
	always_comb begin
		tgt_x = {item.target[LOC_W-1], item.target};
		loc_x = {item.current_location[LOC_W-1], item.current_location};
		if (mode_t'(item.mode) == MODE_ABS) begin
			diff = tgt_x - loc_x;
		end else begin
			diff = tgt_x;
		end
	end

	// magnitude with saturation at the largest step count
	always_comb begin
		mag_x = diff[LOC_W] ? (~diff + 1'b1) : diff;
		span.zero = (diff == '0);
		span.neg  = diff[LOC_W];
		if (mag_x[LOC_W:DIST_W] != '0) begin
			span.mag = '1;
		end else begin
			span.mag = mag_x[DIST_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ===== design/amsb_core.sv =====
// sequencer state registers and per-item next-state and result logic
`default_nettype none
module amsb_core (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [amsb_pkg::BL_W-1:0]        cfg_data,
	input  wire                              fire,
	input  wire  amsb_pkg::item_t            item,
	input  wire  amsb_pkg::dist_t            span,
	output amsb_pkg::res_t                   res
);
	import amsb_pkg::*;

	logic [BL_W-1:0]   backlash_q;
	state_t            state_q,    state_d;
	dir_t              last_dir_q, last_dir_d;
	logic [DIST_W-1:0] move_dist_q, move_dist_d;
	logic [1:0]        kind_q,     kind_d;
	logic [LOC_W-1:0]  exp_loc_q,  exp_loc_d;
	logic              done_q,     done_d;
	logic              stop_q,     stop_d;

	dir_t   new_dir;
	logic   reversal;
	state_t poll_st;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backlash_q <= '0;
		end else if (cfg_we) begin
			backlash_q <= cfg_data;
		end
	end

	// sequencer state, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_dir_q  <= DIR_NONE;
			move_dist_q <= '0;
			kind_q      <= '0;
			exp_loc_q   <= '0;
			done_q      <= 1'b0;
			stop_q      <= 1'b0;
		end else if (fire) begin
			state_q     <= state_d;
			last_dir_q  <= last_dir_d;
			move_dist_q <= move_dist_d;
			kind_q      <= kind_d;
			exp_loc_q   <= exp_loc_d;
			done_q      <= done_d;
			stop_q      <= stop_d;
		end
	end

	// direction of a new move and whether it reverses the last one
	always_comb begin
		new_dir  = span.neg ? DIR_NEG : DIR_POS;
		reversal = (span.neg && last_dir_q == DIR_POS) || (!span.neg && last_dir_q == DIR_NEG);
		poll_st  = stop_q ? ST_DONE : state_q;
	end

	// next state and result for the item
	always_comb begin
		state_d     = state_q;
		last_dir_d  = last_dir_q;
		move_dist_d = move_dist_q;
		kind_d      = kind_q;
		exp_loc_d   = exp_loc_q;
		done_d      = done_q;
		stop_d      = stop_q;
		res         = '0;

		case (mode_t'(item.mode))
			MODE_REL, MODE_ABS: begin
				if (mode_t'(item.mode) == MODE_ABS) begin
					exp_loc_d = item.target;
				end
				if (state_q == ST_IDLE) begin
					kind_d = item.command_type;
					if (!span.zero) begin
						state_d     = reversal ? ST_WAIT_BACKLASH : ST_START;
						move_dist_d = span.mag;
						last_dir_d  = new_dir;
						done_d      = 1'b0;
						stop_d      = 1'b0;
						// take-up move goes out right away
						if (reversal) begin
							res.ctl_write      = 1'b1;
							res.ctl_start      = 1'b1;
							res.ctl_backlash   = 1'b1;
							res.ctl_dir_pos    = (new_dir == DIR_POS);
							res.profile_load   = PROF_MOVE;
							res.distance_write = 1'b1;
							res.distance_value = DIST_W'(backlash_q);
						end
					end
				end
			end
			MODE_POLL: begin
				case (poll_st)
					ST_IDLE: begin
						state_d = ST_IDLE;
					end
					ST_WAIT_BACKLASH: begin
						if (done_q) begin
							done_d  = 1'b0;
							state_d = ST_START;
						end else begin
							state_d = ST_WAIT_BACKLASH;
						end
					end
					ST_START: begin
						res.ctl_write      = 1'b1;
						res.ctl_start      = 1'b1;
						res.ctl_dir_pos    = (last_dir_q == DIR_POS);
						res.ctl_sync       = (kind_t'(kind_q) == KIND_SYNC);
						res.profile_load   = (kind_t'(kind_q) == KIND_JOG ||
						                      kind_t'(kind_q) == KIND_MAXSPD) ?
						                     PROF_MOVE : PROF_TURN;
						res.distance_write = 1'b1;
						res.distance_value = move_dist_q;
						state_d            = ST_WAIT_MOVE;
					end
					ST_WAIT_MOVE: begin
						state_d = done_q ? ST_DONE : ST_WAIT_MOVE;
					end
					default: begin
						// done step: clear control and check final position
						res.ctl_write      = 1'b1;
						res.position_error = (item.current_location != exp_loc_q);
						stop_d             = 1'b0;
						done_d             = 1'b0;
						kind_d             = '0;
						state_d            = ST_IDLE;
					end
				endcase
			end
			MODE_DONE: begin
				done_d = 1'b1;
			end
			MODE_STOP: begin
				stop_d = 1'b1;
			end
			default: begin
				state_d = state_q;
			end
		endcase

		res.axis_state = state_d;
		res.busy_res   = (state_d != ST_IDLE);
	end

endmodule
`default_nettype wire

// ===== design/axis_move_sequencer_backlash.sv =====
// Axis move sequencer with backlash take-up: top level with input and result registers.
// An accepted input beat is held in the item register, and its result in the result register.
// Throughput: one beat per cycle while m_tready is high; the item register feeds the
// sequencer logic, which updates state and fills the result register in the same cycle.
// Reset (arst_n low, asynchronous) returns the axis to idle, direction none,
// backlash steps zero, and empties both pipeline stages.
`default_nettype none
module axis_move_sequencer_backlash (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration: backlash steps
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [amsb_pkg::BL_W-1:0]           cfg_data,
	// input beats
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// target[31:0], command_type[33:32], current_location[65:34], zeros[71:66]
	input  wire  [amsb_pkg::IN_TDATA_W-1:0]     s_tdata,
	// mode[2:0]
	input  wire  [2:0]                          s_tuser,
	// result beats
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// ctl_write[0], ctl_start[1], ctl_backlash[2], ctl_dir_pos[3], ctl_sync[4],
	// profile_load[6:5], distance_write[7], distance_value[38:8], axis_state[41:39],
	// busy_res[42], position_error[43], zeros[47:44]
	output logic [amsb_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import amsb_pkg::*;

	item_t item_s1;
	logic  valid_s1;
	res_t  res_s2;
	logic  valid_s2;
	logic  advance;
	item_t in_item;
	dist_t span;
	res_t  res;

	assign cfg_ready = 1'b1;

	// pipeline handshake
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// unpack input beat
	always_comb begin
		in_item.mode             = s_tuser;
		in_item.target           = s_tdata[31:0];
		in_item.command_type     = s_tdata[33:32];
		in_item.current_location = s_tdata[65:34];
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= in_item;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	amsb_dist u_dist (
		.item (item_s1),
		.span (span)
	);

	amsb_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.fire     (advance),
		.item     (item_s1),
		.span     (span),
		.res      (res)
	);

	// pack result beat
	assign m_tvalid = valid_s2;
	always_comb begin
		m_tdata        = '0;
		m_tdata[0]     = res_s2.ctl_write;
		m_tdata[1]     = res_s2.ctl_start;
		m_tdata[2]     = res_s2.ctl_backlash;
		m_tdata[3]     = res_s2.ctl_dir_pos;
		m_tdata[4]     = res_s2.ctl_sync;
		m_tdata[6:5]   = res_s2.profile_load;
		m_tdata[7]     = res_s2.distance_write;
		m_tdata[38:8]  = res_s2.distance_value;
		m_tdata[41:39] = res_s2.axis_state;
		m_tdata[42]    = res_s2.busy_res;
		m_tdata[43]    = res_s2.position_error;
	end

endmodule
`default_nettype wire
